// File: hw/rtl/swarq_pkg.sv
package swarq_pkg;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MOD  = 4'b0010,
    ST_EMIT = 4'b0100,
    ST_DROP = 4'b1000
  } state_t;

  typedef enum logic [2:0] {
    ACT_LOAD    = 3'd0,
    ACT_SEND    = 3'd1,
    ACT_ACK     = 3'd2,
    ACT_TIMEOUT = 3'd3,
    ACT_FINISH  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    KIND_OK      = 2'd0,
    KIND_CORRUPT = 2'd1,
    KIND_DROP    = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  localparam logic [2:0] CFG_ERR_PERIOD  = 3'd0;
  localparam logic [2:0] CFG_ERR_FIRST   = 3'd1;
  localparam logic [2:0] CFG_LOSS_PERIOD = 3'd2;
  localparam logic [2:0] CFG_LOSS_FIRST  = 3'd3;

  localparam logic [7:0]  PAD_BYTE  = 8'h07;
  localparam logic [7:0]  CHAR_ZERO = 8'h30;
  localparam logic [7:0]  CHAR_ONE  = 8'h31;
  localparam logic [15:0] CRC_POLY  = 16'h1021;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/swarq_ram.sv
module swarq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 20,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/stop_wait_arq_crc_sender.sv
// Stop-and-wait ARQ sender. Load actions store one payload byte each and fold it into a
// CRC-16 (0x1021, init 0) unless an ack is awaited or the buffer is full. A send, or a
// timeout awaiting an ack, first runs a bit-serial remainder pass testing the attempt
// number against the corruption and loss patterns, then emits the PAYLOAD_BYTES+19 byte
// frame, priming the registered payload RAM read before each byte and waiting for a free
// output register (a drop gives a single status transfer instead). A finish with no ack
// awaited emits the end frame the same way without the remainder pass; other actions stay
// idle. New actions are taken only once the previous frame is in the output register.
module stop_wait_arq_crc_sender #(
  parameter int PAYLOAD_BYTES = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_action,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_frame_byte,
  output logic       out_last,
  output logic [1:0] out_attempt_kind,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  import swarq_pkg::*;

  localparam int FRAME = PAYLOAD_BYTES + 19;
  localparam int IW    = $clog2(FRAME);
  localparam int AW    = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int FW    = $clog2(PAYLOAD_BYTES + 1);
  localparam logic [FW-1:0] FILL_MAX  = FW'(PAYLOAD_BYTES);
  localparam logic [IW-1:0] IDX_DLAST = IW'(PAYLOAD_BYTES);
  localparam logic [IW-1:0] IDX_LEN   = IW'(PAYLOAD_BYTES + 1);
  localparam logic [IW-1:0] IDX_CRC0  = IW'(PAYLOAD_BYTES + 2);
  localparam logic [IW-1:0] IDX_CRCL  = IW'(PAYLOAD_BYTES + 17);
  localparam logic [IW-1:0] IDX_LAST  = IW'(FRAME - 1);

  logic [7:0]  err_per_r, err_first_r, loss_per_r, loss_first_r;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        seq_r, seq_nxt;
  logic [31:0] att_r, att_nxt;
  logic        await_r, await_nxt;
  state_t      state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] de_r, de_nxt, dl_r, dl_nxt;
  logic [7:0]  re_r, re_nxt, rl_r, rl_nxt;
  logic        dez_r, dez_nxt, dlz_r, dlz_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic        prime_r, prime_nxt;
  logic        end_r, end_nxt;
  logic        corrupt_r, corrupt_nxt;
  kind_t       kind_r, kind_nxt;
  logic [15:0] crc_sh_r, crc_sh_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;

  logic        out_free, accept, ram_we;
  logic [IW-1:0] slot_w;
  logic [7:0]  ram_rdata, frame_byte;
  logic [FW-1:0] n_w;
  logic [8:0]  te, tl;
  logic        crc_bit, hit_e, hit_l;

  swarq_ram #(.WIDTH(8), .DEPTH(PAYLOAD_BYTES), .AW(AW)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (in_data_byte),
    .raddr (slot_w[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign in_ready         = (state_r == ST_IDLE);
  assign accept           = in_valid && in_ready;
  assign out_free         = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_frame_byte   = out_byte_r;
  assign out_last         = out_last_r;
  assign out_attempt_kind = out_kind_r;

  assign slot_w  = idx_r - IW'(1);
  assign n_w     = end_r ? '0 : fill_r;
  assign ram_we  = accept && (in_action == ACT_LOAD) && !await_r && (fill_r < FILL_MAX);
  assign crc_bit = crc_sh_r[15] ^ (corrupt_r && (idx_r == IDX_CRC0));

  // restoring remainder step, one dividend bit a cycle
  assign te = {re_r, de_r[31]} >= {1'b0, err_per_r} ? {re_r, de_r[31]} - {1'b0, err_per_r}
                                                    : {re_r, de_r[31]};
  assign tl = {rl_r, dl_r[31]} >= {1'b0, loss_per_r} ? {rl_r, dl_r[31]} - {1'b0, loss_per_r}
                                                     : {rl_r, dl_r[31]};
  assign hit_e = (err_per_r == 8'd0) ? dez_r : (te[7:0] == 8'd0);
  assign hit_l = (loss_per_r == 8'd0) ? dlz_r : (tl[7:0] == 8'd0);

  always_comb begin
    priority if (idx_r == '0) begin
      frame_byte = CHAR_ZERO | {7'd0, seq_r};
    end else if (idx_r <= IDX_DLAST) begin
      frame_byte = (slot_w < IW'(n_w)) ? ram_rdata : PAD_BYTE;
    end else if (idx_r == IDX_LEN) begin
      frame_byte = 8'(n_w);
    end else if (idx_r == IDX_LAST) begin
      frame_byte = end_r ? CHAR_ONE : CHAR_ZERO;
    end else begin
      frame_byte = crc_bit ? CHAR_ONE : CHAR_ZERO;
    end
  end

  always_comb begin
    fill_nxt      = fill_r;
    crc_nxt       = crc_r;
    seq_nxt       = seq_r;
    att_nxt       = att_r;
    await_nxt     = await_r;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    de_nxt        = de_r;
    dl_nxt        = dl_r;
    re_nxt        = re_r;
    rl_nxt        = rl_r;
    dez_nxt       = dez_r;
    dlz_nxt       = dlz_r;
    idx_nxt       = idx_r;
    prime_nxt     = prime_r;
    end_nxt       = end_r;
    corrupt_nxt   = corrupt_r;
    kind_nxt      = kind_r;
    crc_sh_nxt    = crc_sh_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_kind_nxt  = out_kind_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_action)
            ACT_LOAD: begin
              if (ram_we) begin
                fill_nxt = fill_r + FW'(1);
                crc_nxt  = crc_update(crc_r, in_data_byte);
              end
            end
            ACT_SEND, ACT_TIMEOUT: begin
              if (in_action == ACT_SEND || await_r) begin
                att_nxt   = att_r + 32'd1;
                await_nxt = 1'b1;
                de_nxt    = (att_r >= {24'd0, err_first_r}) ? att_r - {24'd0, err_first_r}
                                                           : {24'd0, err_first_r} - att_r;
                dl_nxt    = (att_r >= {24'd0, loss_first_r}) ? att_r - {24'd0, loss_first_r}
                                                            : {24'd0, loss_first_r} - att_r;
                dez_nxt   = (att_r == {24'd0, err_first_r});
                dlz_nxt   = (att_r == {24'd0, loss_first_r});
                re_nxt    = '0;
                rl_nxt    = '0;
                cnt_nxt   = '0;
                state_nxt = ST_MOD;
              end
            end
            ACT_ACK: begin
              if (await_r) begin
                await_nxt = 1'b0;
                seq_nxt   = !seq_r;
                fill_nxt  = '0;
                crc_nxt   = '0;
              end
            end
            ACT_FINISH: begin
              if (!await_r) begin
                end_nxt     = 1'b1;
                corrupt_nxt = 1'b0;
                kind_nxt    = KIND_END;
                idx_nxt     = '0;
                prime_nxt   = 1'b0;
                crc_sh_nxt  = '0;
                state_nxt   = ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MOD: begin
        re_nxt  = te[7:0];
        rl_nxt  = tl[7:0];
        de_nxt  = {de_r[30:0], 1'b0};
        dl_nxt  = {dl_r[30:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          end_nxt     = 1'b0;
          idx_nxt     = '0;
          prime_nxt   = 1'b0;
          crc_sh_nxt  = crc_r;
          corrupt_nxt = hit_e;
          if (hit_e) begin
            kind_nxt  = KIND_CORRUPT;
            state_nxt = ST_EMIT;
          end else if (hit_l) begin
            kind_nxt  = KIND_DROP;
            state_nxt = ST_DROP;
          end else begin
            kind_nxt  = KIND_OK;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (!prime_r) begin
          prime_nxt = 1'b1;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = frame_byte;
          out_last_nxt  = (idx_r == IDX_LAST);
          out_kind_nxt  = kind_r;
          prime_nxt     = 1'b0;
          idx_nxt       = idx_r + IW'(1);
          if (idx_r >= IDX_CRC0 && idx_r <= IDX_CRCL) begin
            crc_sh_nxt = {crc_sh_r[14:0], 1'b0};
          end
          if (idx_r == IDX_LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DROP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = 8'd0;
          out_last_nxt  = 1'b1;
          out_kind_nxt  = KIND_DROP;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_per_r    <= 8'd10;
      err_first_r  <= 8'd3;
      loss_per_r   <= 8'd10;
      loss_first_r <= 8'd8;
      fill_r       <= '0;
      crc_r        <= '0;
      seq_r        <= 1'b0;
      att_r        <= '0;
      await_r      <= 1'b0;
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ERR_PERIOD:  err_per_r    <= cfg_wdata;
          CFG_ERR_FIRST:   err_first_r  <= cfg_wdata;
          CFG_LOSS_PERIOD: loss_per_r   <= cfg_wdata;
          CFG_LOSS_FIRST:  loss_first_r <= cfg_wdata;
          default: ;
        endcase
      end
      fill_r      <= fill_nxt;
      crc_r       <= crc_nxt;
      seq_r       <= seq_nxt;
      att_r       <= att_nxt;
      await_r     <= await_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    de_r       <= de_nxt;
    dl_r       <= dl_nxt;
    re_r       <= re_nxt;
    rl_r       <= rl_nxt;
    dez_r      <= dez_nxt;
    dlz_r      <= dlz_nxt;
    idx_r      <= idx_nxt;
    prime_r    <= prime_nxt;
    end_r      <= end_nxt;
    corrupt_r  <= corrupt_nxt;
    kind_r     <= kind_nxt;
    crc_sh_r   <= crc_sh_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_kind_r <= out_kind_nxt;
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX) else $error("fill count beyond payload size");

  a_send_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_action == ACT_SEND |=> state_r == ST_MOD && await_r)
    else $error("send did not start an attempt");

  a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_DROP |-> out_last_r && out_byte_r == 8'd0)
    else $error("drop status malformed");

  a_emit_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |=> $stable(fill_r) && $stable(crc_r))
    else $error("state changed during frame emission");
`endif
endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import swarq_pkg::*;

  localparam int PAYLOAD_BYTES = 20;
  localparam int FRAME_LEN = PAYLOAD_BYTES + 19;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
    logic [1:0] kind;
  } frame_item_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] in_action;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_frame_byte;
  logic       out_last;
  logic [1:0] out_attempt_kind;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_wdata;

  stop_wait_arq_crc_sender #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_frame_byte(out_frame_byte), .out_last(out_last),
    .out_attempt_kind(out_attempt_kind),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // sender model state
  logic [7:0]  err_period, err_first, loss_period, loss_first;
  logic [7:0]  payload [PAYLOAD_BYTES];
  logic [4:0]  fill;
  logic [15:0] crc;
  logic        seq;
  logic [31:0] attempt_no;
  logic        waiting_ack;

  frame_item_t expected_frames[$];
  int mismatches;
  int items_sent;
  int stall_left;
  bit idle_en;
  bit stall_en;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [15:0] crc_step(logic [15:0] c_in, logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    return c;
  endfunction

  function automatic bit fault_hit(logic [31:0] a, logic [7:0] first, logic [7:0] period);
    logic [31:0] d;
    d = (a >= {24'd0, first}) ? a - first : {24'd0, first} - a;
    if (period == 0) return d == 0;
    return (d % period) == 0;
  endfunction

  task automatic queue_frame(kind_t kind, bit corrupt, bit end_frame);
    logic [7:0]  f [FRAME_LEN];
    logic [4:0]  n;
    logic [15:0] c;
    frame_item_t it;
    n = end_frame ? 5'd0 : fill;
    c = end_frame ? 16'd0 : crc;
    f[0] = CHAR_ZERO + seq;
    for (int i = 0; i < PAYLOAD_BYTES; i++) f[1 + i] = (i < n) ? payload[i] : PAD_BYTE;
    f[1 + PAYLOAD_BYTES] = {3'd0, n};
    for (int i = 0; i < 16; i++) f[2 + PAYLOAD_BYTES + i] = c[15 - i] ? CHAR_ONE : CHAR_ZERO;
    f[FRAME_LEN - 1] = end_frame ? CHAR_ONE : CHAR_ZERO;
    if (corrupt)
      f[2 + PAYLOAD_BYTES] = (f[2 + PAYLOAD_BYTES] == CHAR_ONE) ? CHAR_ZERO : CHAR_ONE;
    for (int i = 0; i < FRAME_LEN; i++) begin
      it.frame_byte = f[i];
      it.last = (i == FRAME_LEN - 1);
      it.kind = kind;
      expected_frames.push_back(it);
    end
  endtask

  task automatic predict_attempt();
    logic [31:0] a;
    frame_item_t it;
    a = attempt_no;
    attempt_no = a + 1;
    waiting_ack = 1;
    if (fault_hit(a, err_first, err_period)) begin
      queue_frame(KIND_CORRUPT, 1, 0);
    end else if (fault_hit(a, loss_first, loss_period)) begin
      it.frame_byte = 8'd0;
      it.last = 1;
      it.kind = KIND_DROP;
      expected_frames.push_back(it);
    end else begin
      queue_frame(KIND_OK, 0, 0);
    end
  endtask

  task automatic predict_action(logic [2:0] act, logic [7:0] b);
    case (act)
      ACT_LOAD: begin
        if (!waiting_ack && fill < PAYLOAD_BYTES) begin
          payload[fill] = b;
          fill = fill + 1;
          crc = crc_step(crc, b);
        end
      end
      ACT_SEND: predict_attempt();
      ACT_ACK: begin
        if (waiting_ack) begin
          waiting_ack = 0;
          seq = ~seq;
          fill = 0;
          crc = 0;
        end
      end
      ACT_TIMEOUT: if (waiting_ack) predict_attempt();
      ACT_FINISH: if (!waiting_ack) queue_frame(KIND_END, 0, 1);
      default: ;
    endcase
  endtask

  // valid stays high after a transfer until the next item or a gap replaces it
  task automatic send_action(logic [2:0] act, logic [7:0] b);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1;
    in_action <= act;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    predict_action(act, b);
    items_sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_ERR_PERIOD:  err_period = val;
      CFG_ERR_FIRST:   err_first = val;
      CFG_LOSS_PERIOD: loss_period = val;
      CFG_LOSS_FIRST:  loss_first = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_faults(logic [7:0] ep, logic [7:0] ef, logic [7:0] lp, logic [7:0] lf);
    drain();
    write_reg(CFG_ERR_PERIOD, ep);
    write_reg(CFG_ERR_FIRST, ef);
    write_reg(CFG_LOSS_PERIOD, lp);
    write_reg(CFG_LOSS_FIRST, lf);
    cfg_we <= 0;
  endtask

  // load n bytes, send, maybe time out, then ack
  task automatic send_message(int n, bit random_bytes);
    for (int i = 0; i < n; i++)
      send_action(ACT_LOAD, random_bytes ? 8'($urandom) : 8'(i * 37));
    send_action(ACT_SEND, 8'($urandom));
    repeat ($urandom_range(0, 2)) send_action(ACT_TIMEOUT, 8'($urandom));
    send_action(ACT_ACK, 8'($urandom));
  endtask

  task automatic test_directed();
    send_action(ACT_FINISH, 8'h00);
    send_action(ACT_ACK, 8'hff);
    send_action(ACT_TIMEOUT, 8'h00);
    send_action(ACT_SEND, 8'h00);
    send_action(ACT_LOAD, 8'hff);
    send_action(ACT_FINISH, 8'h00);
    send_action(ACT_SEND, 8'h00);
    send_action(ACT_TIMEOUT, 8'h00);
    send_action(ACT_ACK, 8'h00);
    send_action(ACT_LOAD, 8'h00);
    send_action(ACT_LOAD, 8'hff);
    send_action(3'd5, 8'h55);
    send_action(3'd6, 8'haa);
    send_action(3'd7, 8'hff);
    send_action(ACT_SEND, 8'h00);
    send_action(ACT_ACK, 8'h00);
    send_action(ACT_FINISH, 8'h00);
  endtask

  task automatic test_full_buffer();
    for (int i = 0; i < PAYLOAD_BYTES + 2; i++) send_action(ACT_LOAD, 8'($urandom));
    send_action(ACT_SEND, 8'h00);
    send_action(ACT_ACK, 8'h00);
  endtask

  task automatic test_fault_settings();
    set_faults(8'd1, 8'd255, 8'd1, 8'd0);
    send_message(3, 1);
    set_faults(8'd255, 8'd0, 8'd1, 8'd0);
    send_message(2, 1);
    send_message(0, 1);
    set_faults(8'd0, 8'd200, 8'd0, 8'd9);
    send_message(1, 1);
    drain();
    cfg_we <= 1;
    cfg_index <= 3'd5;
    cfg_wdata <= 8'hff;
    @(posedge clk);
    cfg_we <= 0;
    set_faults(8'd3, 8'd1, 8'd4, 8'd2);
  endtask

  task automatic test_random(int n_items);
    int start;
    int r;
    start = items_sent;
    while (items_sent - start < n_items) begin
      r = $urandom_range(0, 9);
      if (r < 8) begin
        send_message($urandom_range(0, 4) == 0 ? PAYLOAD_BYTES : $urandom_range(0, 6), 1);
      end else begin
        send_action(3'($urandom_range(0, 7)), 8'($urandom));
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    frame_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer byte=%h", out_frame_byte);
      end else begin
        want = expected_frames.pop_front();
        if (out_frame_byte !== want.frame_byte || out_last !== want.last ||
            out_attempt_kind !== want.kind) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h/%b/%0d got %h/%b/%0d", want.frame_byte, want.last,
                     want.kind, out_frame_byte, out_last, out_attempt_kind);
        end
      end
    end
  end

  // output stalls in bursts of random length while stall_en is set
  always @(posedge clk) begin
    if (!stall_en) begin
      out_ready <= 1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= (stall_left == 1);
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready <= 0;
      stall_left <= $urandom_range(1, 13);
    end else begin
      out_ready <= 1;
    end
  end

  initial begin
    in_valid = 0;
    in_action = ACT_LOAD;
    in_data_byte = 0;
    out_ready = 0;
    cfg_we = 0;
    cfg_index = CFG_ERR_PERIOD;
    cfg_wdata = 0;
    rst_n = 0;
    mismatches = 0;
    items_sent = 0;
    idle_en = 1;
    stall_en = 1;
    err_period = 10; err_first = 3; loss_period = 10; loss_first = 8;
    fill = 0; crc = 0; seq = 0; attempt_no = 0; waiting_ack = 0;
    for (int i = 0; i < PAYLOAD_BYTES; i++) payload[i] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_full_buffer();
    test_fault_settings();
    test_random(330);
    set_faults(8'd7, 8'd2, 8'd5, 8'd4);
    idle_en = 0;
    stall_en = 0;
    test_random(80);
    drain();
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/swarq_pkg.sv
hw/rtl/swarq_ram.sv
hw/rtl/stop_wait_arq_crc_sender.sv
verif/tb_top.sv
